@@ src/led_fade_blink_sequencer_assert.svh @@
// Assertion macros shared by the LED fade and blink sequencer modules.
// Needs no other file; the user module supplies i_clk and i_rst_n.
`ifndef LED_FADE_BLINK_SEQUENCER_ASSERT_SVH
`define LED_FADE_BLINK_SEQUENCER_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside reset.
`define LFBS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lfbs assertion failed");
// Next-cycle implication.
`define LFBS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lfbs assertion failed");
`else
`define LFBS_ASSERT_IMP(lbl, ante, cons)
`define LFBS_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

@@ src/lfbs_pkg.sv @@
// Package of the LED fade and blink sequencer: widths, codes and item types.
// Depends on nothing; the sequencer, the divider and the testbench use it.
package lfbs_pkg;

    localparam int ELAPSED_BITS_DEF = 20;

    localparam int LEVEL_BITS    = 7;
    localparam int SPAN_BITS     = 16;
    localparam int RAMP_BITS     = 7;
    localparam int REPEAT_BITS   = 8;
    localparam int REPEATS_BITS  = 9;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    // Ramp length in ticks is span * ramp / 10, below 2^20.
    localparam int RAMP_TICK_BITS = 20;
    localparam int RAMP_NUM_BITS  = SPAN_BITS + RAMP_BITS;
    localparam int SPAN10_BITS    = 20;

    // Quotient bits produced by the serial divider for each division.
    localparam int DIV_STEP_BITS = 5;
    localparam logic [DIV_STEP_BITS-1:0] RAMP_STEPS   = 5'd20;
    localparam logic [DIV_STEP_BITS-1:0] INTERP_STEPS = 5'd7;
    localparam logic [RAMP_TICK_BITS-1:0] RAMP_DIVISOR = 20'd10;

    localparam logic [LEVEL_BITS-1:0]   LEVEL_FULL   = 7'd100;
    localparam logic [LEVEL_BITS-1:0]   LEVEL_OFF    = 7'd0;
    localparam logic [LEVEL_BITS-1:0]   PWM_LAST     = 7'd99;
    localparam logic [REPEATS_BITS-1:0] ENDLESS_MARK = 9'h100;

    localparam logic CMD_TICK    = 1'b0;
    localparam logic CMD_RESTART = 1'b1;

    localparam logic [CFG_IDX_BITS-1:0] CFG_LEVEL_FIRST  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPAN_FIRST   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RAMP_FIRST   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LEVEL_SECOND = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPAN_SECOND  = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RAMP_SECOND  = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_REPEAT_TOTAL = 3'd6;

    typedef struct packed {
        logic cmd;
        logic button_pressed;
    } t_in_item;

    typedef struct packed {
        logic                  led_on;
        logic [LEVEL_BITS-1:0] level_now;
        logic                  in_phase_two;
        logic                  finished;
    } t_out_item;

    // Start request to the serial divider.
    typedef struct packed {
        logic                     start;
        logic [DIV_STEP_BITS-1:0] steps;
    } t_div_ctl;

endpackage

@@ src/lfbs_stream_if.sv @@
// Valid/ready stream interface carrying one payload type per channel.
// Depends on nothing; the payload type is set where the channel is declared.
interface lfbs_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ src/led_fade_blink_sequencer.sv @@
// LED fade and blink sequencer for one LED channel: top level.
// Depends on lfbs_pkg, lfbs_stream_if, lfbs_divider and the assertion header.
//
// Usage. Each input transaction on i_in carries a command and the button
// level. A restart command reloads the repeat count, returns to the start of
// phase one and produces no output transaction. A tick command advances the
// sequence by one tick and produces exactly one output transaction on o_out
// with the LED drive bit, the target brightness, the phase and the finished
// flag. Configuration registers are written through i_cfg_we, i_cfg_idx and
// i_cfg_data while no tick is in flight; they are read live on every tick.
// The block handles one transaction at a time. A tick whose phase is
// ramping uses the serial divider twice from acceptance to a valid result:
// first for the ramp length (span * ramp / 10), then for the interpolation
// quotient. A tick past the ramp needs only the ramp length, and a tick
// while the button is held or after the sequence has finished needs no
// division. Both divisions share the one serial divider. Reset clears the
// configuration, the sequence state (finished, LED off) and the output
// register. When the receiver stalls, the result waits in the output
// register; the next tick is still accepted and computed, and is held back
// only at its final commit.
`include "led_fade_blink_sequencer_assert.svh"

module led_fade_blink_sequencer #(
    parameter int ELAPSED_BITS = lfbs_pkg::ELAPSED_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    lfbs_stream_if.sink                          i_in,
    lfbs_stream_if.source                        o_out,
    input  logic                                 i_cfg_we,
    input  logic [lfbs_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [lfbs_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);

    localparam int LB = lfbs_pkg::LEVEL_BITS;
    localparam int SB = lfbs_pkg::SPAN_BITS;
    localparam int RB = lfbs_pkg::RAMP_BITS;
    localparam int TB = lfbs_pkg::RAMP_TICK_BITS;
    localparam int QB = lfbs_pkg::REPEATS_BITS;
    // Divider dividend width: level difference times elapsed ticks.
    localparam int NW = ELAPSED_BITS + LB;
    // Compare width for elapsed ticks against tick counts of 20 bits.
    localparam int CW = (ELAPSED_BITS > TB) ? ELAPSED_BITS : TB;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RAMP,
        S_CHECK,
        S_INTERP,
        S_FINISH
    } t_state;

    // Configuration registers.
    logic [LB-1:0]                   r_level_first;
    logic [SB-1:0]                   r_span_first;
    logic [RB-1:0]                   r_ramp_first;
    logic [LB-1:0]                   r_level_second;
    logic [SB-1:0]                   r_span_second;
    logic [RB-1:0]                   r_ramp_second;
    logic [lfbs_pkg::REPEAT_BITS-1:0] r_repeat_total;

    // Sequence state.
    t_state                  r_state;
    logic [ELAPSED_BITS-1:0] r_elapsed;
    logic                    r_second;
    logic [QB-1:0]           r_repeats;
    logic [LB-1:0]           r_pwm;
    logic                    r_btn;
    logic [TB-1:0]           r_ramp_ticks;
    logic [LB-1:0]           r_target;
    logic                    r_out_valid;
    lfbs_pkg::t_out_item     r_out;

    // Parameters of the running phase.
    logic [LB-1:0]   w_from;
    logic [LB-1:0]   w_to;
    logic [SB-1:0]   w_span;
    logic [RB-1:0]   w_ramp;
    logic [LB:0]     w_diff;
    logic [LB-1:0]   w_mag;
    logic [lfbs_pkg::RAMP_NUM_BITS-1:0] w_ramp_num;
    logic [NW-1:0]   w_interp_num;
    logic [SB+3:0]   w_span10;
    logic            w_span_zero;
    logic            w_phase_end;
    logic            w_past_ramp;
    logic            w_tick_in;
    logic            w_commit;

    // Divider hookup.
    lfbs_pkg::t_div_ctl w_div_ctl;
    logic [TB-1:0]      w_div_rem;
    logic [NW-1:0]      w_div_num;
    logic [TB-1:0]      w_div_den;
    logic               w_div_done;
    logic [TB-1:0]      w_div_quot;

    // Values committed when a tick completes.
    t_state                  n_state;
    lfbs_pkg::t_out_item     n_out;
    logic [ELAPSED_BITS-1:0] n_elapsed;
    logic                    n_second;
    logic [QB-1:0]           n_repeats;
    logic [QB-1:0]           n_repeats_dec;
    logic [LB-1:0]           n_pwm;
    logic [LB-1:0]           n_target;

    always_comb begin
        if (!r_second) begin
            w_from = r_level_second;
            w_to   = r_level_first;
            w_span = r_span_first;
            w_ramp = r_ramp_first;
        end else begin
            w_from = r_level_first;
            w_to   = r_level_second;
            w_span = r_span_second;
            w_ramp = r_ramp_second;
        end
        w_diff       = {1'b0, w_to} - {1'b0, w_from};
        w_mag        = w_diff[LB] ? LB'(-w_diff) : w_diff[LB-1:0];
        w_ramp_num   = lfbs_pkg::RAMP_NUM_BITS'(w_span) * lfbs_pkg::RAMP_NUM_BITS'(w_ramp);
        w_interp_num = NW'(w_mag) * NW'(r_elapsed);
        w_span10     = ({4'b0, w_span} << 3) + ({4'b0, w_span} << 1);
        w_span_zero  = (w_span == '0);
        w_phase_end  = !w_span_zero && (CW'(r_elapsed) >= CW'(w_span10));
        w_past_ramp  = w_span_zero || (CW'(r_elapsed) >= CW'(r_ramp_ticks));
        w_tick_in    = i_in.valid && i_in.ready && (i_in.payload.cmd == lfbs_pkg::CMD_TICK);
        w_commit     = (r_state == S_FINISH) && (!r_out_valid || o_out.ready);
    end

    // The divider first computes the ramp length, then the interpolation
    // quotient |to - from| * age / ramp_ticks, which is below 128.
    always_comb begin
        w_div_ctl.start = 1'b0;
        w_div_ctl.steps = lfbs_pkg::RAMP_STEPS;
        w_div_rem       = TB'(w_ramp_num >> lfbs_pkg::RAMP_STEPS);
        w_div_num       = NW'(w_ramp_num) << (NW - TB);
        w_div_den       = lfbs_pkg::RAMP_DIVISOR;
        if (r_state == S_IDLE) begin
            w_div_ctl.start = w_tick_in && !i_in.payload.button_pressed && (r_repeats != '0);
        end else begin
            w_div_ctl.start = (r_state == S_CHECK) && !w_past_ramp;
            w_div_ctl.steps = lfbs_pkg::INTERP_STEPS;
            w_div_rem       = TB'(w_interp_num >> LB);
            w_div_num       = w_interp_num << (NW - LB);
            w_div_den       = r_ramp_ticks;
        end
    end

    lfbs_divider #(
        .NUM_BITS (NW),
        .DEN_BITS (TB)
    ) u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_div_ctl),
        .i_rem   (w_div_rem),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_quot  (w_div_quot)
    );

    // Result and state update of a completed tick.
    always_comb begin
        n_elapsed     = (&r_elapsed) ? r_elapsed : r_elapsed + 1'b1;
        n_second      = r_second;
        n_repeats     = r_repeats;
        n_repeats_dec = r_repeats;
        n_pwm         = (r_pwm >= lfbs_pkg::PWM_LAST) ? '0 : r_pwm + 1'b1;
        n_target      = w_diff[LB] ? w_from - LB'(w_div_quot) : w_from + LB'(w_div_quot);
        n_out.led_on       = 1'b0;
        n_out.level_now    = lfbs_pkg::LEVEL_OFF;
        n_out.in_phase_two = 1'b0;
        n_out.finished     = 1'b1;
        if (r_btn) begin
            n_out.led_on       = 1'b1;
            n_out.level_now    = lfbs_pkg::LEVEL_FULL;
            n_out.in_phase_two = (r_repeats != '0) && r_second;
            n_out.finished     = (r_repeats == '0);
        end else if (r_repeats != '0) begin
            n_out.led_on       = (r_pwm < r_target);
            n_out.level_now    = r_target;
            n_out.in_phase_two = r_second;
            n_out.finished     = 1'b0;
            if (w_phase_end) begin
                n_elapsed = ELAPSED_BITS'(1);
                if (!r_second) begin
                    n_second = 1'b1;
                end else begin
                    // A finite count loses one repeat; the endless mark stays.
                    if (!r_repeats[QB-1]) begin
                        n_repeats_dec = r_repeats - 1'b1;
                    end
                    n_repeats = n_repeats_dec;
                    if (n_repeats_dec != '0) begin
                        n_second = 1'b0;
                    end else begin
                        n_out.led_on       = 1'b0;
                        n_out.level_now    = lfbs_pkg::LEVEL_OFF;
                        n_out.in_phase_two = 1'b0;
                        n_out.finished     = 1'b1;
                    end
                end
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_tick_in) begin
                    n_state = w_div_ctl.start ? S_RAMP : S_FINISH;
                end
            end
            S_RAMP: begin
                if (w_div_done) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = w_past_ramp ? S_FINISH : S_INTERP;
            end
            S_INTERP: begin
                if (w_div_done) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (w_commit) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State machine, sequence state and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_elapsed    <= '0;
            r_second     <= 1'b0;
            r_repeats    <= '0;
            r_pwm        <= '0;
            r_btn        <= 1'b0;
            r_ramp_ticks <= '0;
            r_target     <= '0;
            r_out        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_in.valid && i_in.ready) begin
                r_btn <= i_in.payload.button_pressed;
                if (i_in.payload.cmd == lfbs_pkg::CMD_RESTART) begin
                    r_second  <= 1'b0;
                    r_elapsed <= '0;
                    r_repeats <= (r_repeat_total != '0) ? {1'b0, r_repeat_total}
                                                         : lfbs_pkg::ENDLESS_MARK;
                end
            end
            if ((r_state == S_RAMP) && w_div_done) begin
                r_ramp_ticks <= w_div_quot;
            end
            if (r_state == S_CHECK) begin
                r_target <= w_to;
            end
            if ((r_state == S_INTERP) && w_div_done) begin
                r_target <= n_target;
            end
            if (w_commit) begin
                r_elapsed   <= n_elapsed;
                r_second    <= n_second;
                r_repeats   <= n_repeats;
                r_pwm       <= n_pwm;
                r_out       <= n_out;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Configuration writes; an index beyond the list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level_first  <= '0;
            r_span_first   <= '0;
            r_ramp_first   <= '0;
            r_level_second <= '0;
            r_span_second  <= '0;
            r_ramp_second  <= '0;
            r_repeat_total <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lfbs_pkg::CFG_LEVEL_FIRST:  r_level_first  <= i_cfg_data[LB-1:0];
                lfbs_pkg::CFG_SPAN_FIRST:   r_span_first   <= i_cfg_data[SB-1:0];
                lfbs_pkg::CFG_RAMP_FIRST:   r_ramp_first   <= i_cfg_data[RB-1:0];
                lfbs_pkg::CFG_LEVEL_SECOND: r_level_second <= i_cfg_data[LB-1:0];
                lfbs_pkg::CFG_SPAN_SECOND:  r_span_second  <= i_cfg_data[SB-1:0];
                lfbs_pkg::CFG_RAMP_SECOND:  r_ramp_second  <= i_cfg_data[RB-1:0];
                lfbs_pkg::CFG_REPEAT_TOTAL: r_repeat_total <= i_cfg_data[lfbs_pkg::REPEAT_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    assign i_in.ready    = (r_state == S_IDLE);
    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

    `LFBS_ASSERT_IMP(a_finished_not_phase_two, o_out.valid && o_out.payload.finished,
                     !o_out.payload.in_phase_two)
    `LFBS_ASSERT_IMP(a_pwm_in_period, 1'b1, r_pwm <= lfbs_pkg::PWM_LAST)
    `LFBS_ASSERT_NXT(a_tick_leaves_idle, w_tick_in, r_state != S_IDLE)
    `LFBS_ASSERT_IMP(a_off_when_finished, o_out.valid && o_out.payload.finished
                     && !o_out.payload.led_on, o_out.payload.level_now == lfbs_pkg::LEVEL_OFF)

endmodule

@@ src/lfbs_divider.sv @@
// Restoring divider, one quotient bit per cycle, for the sequencer.
// Depends on lfbs_pkg and the assertion macro header.
`include "led_fade_blink_sequencer_assert.svh"

module lfbs_divider #(
    parameter int NUM_BITS = 27,
    parameter int DEN_BITS = 20
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  lfbs_pkg::t_div_ctl   i_ctl,
    // The caller preloads the partial remainder (below the divisor) and
    // places the remaining dividend bits at the top of i_num.
    input  logic [DEN_BITS-1:0]  i_rem,
    input  logic [NUM_BITS-1:0]  i_num,
    input  logic [DEN_BITS-1:0]  i_den,
    output logic                 o_done,
    output logic [DEN_BITS-1:0]  o_quot
);

    logic                               r_busy;
    logic                               r_done;
    logic [lfbs_pkg::DIV_STEP_BITS-1:0] r_count;
    logic [DEN_BITS-1:0]                r_rem;
    logic [NUM_BITS-1:0]                r_num;
    logic [DEN_BITS-1:0]                r_den;
    logic [DEN_BITS-1:0]                r_quot;

    logic [DEN_BITS:0] n_shift;
    logic [DEN_BITS:0] n_diff;
    logic              n_ge;

    always_comb begin
        n_shift = {r_rem, r_num[NUM_BITS-1]};
        n_ge    = (n_shift >= {1'b0, r_den});
        n_diff  = n_shift - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy  <= 1'b1;
                r_count <= i_ctl.steps;
            end else if (r_busy) begin
                r_count <= r_count - 1'b1;
                if (r_count == lfbs_pkg::DIV_STEP_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_rem  <= i_rem;
            r_num  <= i_num;
            r_den  <= i_den;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= n_ge ? n_diff[DEN_BITS-1:0] : n_shift[DEN_BITS-1:0];
            r_num  <= r_num << 1;
            r_quot <= {r_quot[DEN_BITS-2:0], n_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

    `LFBS_ASSERT_IMP(a_no_restart_busy, i_ctl.start, !r_busy)
    `LFBS_ASSERT_IMP(a_rem_below_den, r_busy, r_rem < r_den)
    `LFBS_ASSERT_NXT(a_done_ends_busy, r_busy && r_count == lfbs_pkg::DIV_STEP_BITS'(1),
                     o_done && !r_busy)

endmodule

@@ dv/tb_led_fade_blink_sequencer.sv @@
// Self-checking testbench for the one-channel LED fade and blink sequencer.
// Depends on lfbs_pkg, lfbs_stream_if and led_fade_blink_sequencer from the RTL.
// Directed table first, then randomized register sets under varying backpressure.
`timescale 1ns / 1ps

module tb_led_fade_blink_sequencer;

    localparam int AGE_BITS         = lfbs_pkg::ELAPSED_BITS_DEF;
    localparam int SETTLE_CYCLES    = 40;    // quiet time before registers may change
    localparam int WATCHDOG_LIMIT   = 3000;  // quiet cycles before the run is abandoned
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int NUM_SETS         = 14;
    localparam int ITEMS_PER_SET    = 48;

    // Input transactions used by the directed table.
    localparam lfbs_pkg::t_in_item TICK    = '{cmd: lfbs_pkg::CMD_TICK,    button_pressed: 1'b0};
    localparam lfbs_pkg::t_in_item PRESS   = '{cmd: lfbs_pkg::CMD_TICK,    button_pressed: 1'b1};
    localparam lfbs_pkg::t_in_item RESTART = '{cmd: lfbs_pkg::CMD_RESTART, button_pressed: 1'b0};

    // Results that can be read straight off the behavior.
    localparam lfbs_pkg::t_out_item DONE_RESULT = '{1'b0, lfbs_pkg::LEVEL_OFF, 1'b0, 1'b1};
    localparam lfbs_pkg::t_out_item FORCED_DONE = '{1'b1, lfbs_pkg::LEVEL_FULL, 1'b0, 1'b1};
    localparam lfbs_pkg::t_out_item FORCED_RUN  = '{1'b1, lfbs_pkg::LEVEL_FULL, 1'b0, 1'b0};
    localparam lfbs_pkg::t_out_item HELD_TOP    = '{1'b1, 7'd127, 1'b0, 1'b0};
    localparam lfbs_pkg::t_out_item UNTYPED     = '0;

    typedef enum logic {ROW_REG, ROW_ITEM} t_row_kind;

    // One directed step: a register write, or a run of identical transactions.
    // Item rows carry CFG_LEVEL_FIRST only as a filler for the unused index.
    typedef struct packed {
        t_row_kind                          kind;
        logic [lfbs_pkg::CFG_IDX_BITS-1:0]  reg_idx;
        logic [lfbs_pkg::CFG_DATA_BITS-1:0] reg_val;
        lfbs_pkg::t_in_item                 item;
        logic [7:0]                         count;
        logic                               typed;
        lfbs_pkg::t_out_item                want;
    } t_row;

    localparam int NUM_ROWS = 18;
    localparam t_row DIRECTED_ROWS [NUM_ROWS] = '{
        // Out of reset the sequence is finished, forced or not.
        '{ROW_ITEM, lfbs_pkg::CFG_LEVEL_FIRST,  16'd0,   TICK,    8'd1,  1'b1, DONE_RESULT},
        '{ROW_ITEM, lfbs_pkg::CFG_LEVEL_FIRST,  16'd0,   PRESS,   8'd1,  1'b1, FORCED_DONE},
        // A level above 100 with a zero span holds forever and stays lit.
        '{ROW_REG,  lfbs_pkg::CFG_LEVEL_FIRST,  16'd127, TICK,    8'd0,  1'b0, UNTYPED},
        '{ROW_ITEM, lfbs_pkg::CFG_LEVEL_FIRST,  16'd0,   RESTART, 8'd1,  1'b0, UNTYPED},
        '{ROW_ITEM, lfbs_pkg::CFG_LEVEL_FIRST,  16'd0,   TICK,    8'd1,  1'b1, HELD_TOP},
        // One full cycle of ten ticks per phase, single repeat.
        '{ROW_REG,  lfbs_pkg::CFG_LEVEL_FIRST,  16'd100, TICK,    8'd0,  1'b0, UNTYPED},
        '{ROW_REG,  lfbs_pkg::CFG_SPAN_FIRST,   16'd1,   TICK,    8'd0,  1'b0, UNTYPED},
        '{ROW_REG,  lfbs_pkg::CFG_RAMP_FIRST,   16'd100, TICK,    8'd0,  1'b0, UNTYPED},
        '{ROW_REG,  lfbs_pkg::CFG_LEVEL_SECOND, 16'd0,   TICK,    8'd0,  1'b0, UNTYPED},
        '{ROW_REG,  lfbs_pkg::CFG_SPAN_SECOND,  16'd1,   TICK,    8'd0,  1'b0, UNTYPED},
        '{ROW_REG,  lfbs_pkg::CFG_RAMP_SECOND,  16'd127, TICK,    8'd0,  1'b0, UNTYPED},
        '{ROW_REG,  lfbs_pkg::CFG_REPEAT_TOTAL, 16'd1,   TICK,    8'd0,  1'b0, UNTYPED},
        '{ROW_ITEM, lfbs_pkg::CFG_LEVEL_FIRST,  16'd0,   RESTART, 8'd1,  1'b0, UNTYPED},
        '{ROW_ITEM, lfbs_pkg::CFG_LEVEL_FIRST,  16'd0,   TICK,    8'd9,  1'b0, UNTYPED},
        // A pressed tick still ages the phase, so the flip comes on the next tick.
        '{ROW_ITEM, lfbs_pkg::CFG_LEVEL_FIRST,  16'd0,   PRESS,   8'd1,  1'b1, FORCED_RUN},
        '{ROW_ITEM, lfbs_pkg::CFG_LEVEL_FIRST,  16'd0,   TICK,    8'd1,  1'b0, UNTYPED},
        // Falling ramp longer than the phase, ending on the last repeat.
        '{ROW_ITEM, lfbs_pkg::CFG_LEVEL_FIRST,  16'd0,   TICK,    8'd10, 1'b0, UNTYPED},
        '{ROW_ITEM, lfbs_pkg::CFG_LEVEL_FIRST,  16'd0,   TICK,    8'd1,  1'b1, DONE_RESULT}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic                               i_cfg_we;
    logic [lfbs_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx;
    logic [lfbs_pkg::CFG_DATA_BITS-1:0] i_cfg_data;

    lfbs_stream_if #(.t_payload(lfbs_pkg::t_in_item))  in_if ();
    lfbs_stream_if #(.t_payload(lfbs_pkg::t_out_item)) out_if ();

    led_fade_blink_sequencer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of the registers and the sequence state.
    logic [lfbs_pkg::LEVEL_BITS-1:0]   cfg_level_first, cfg_level_second;
    logic [lfbs_pkg::SPAN_BITS-1:0]    cfg_span_first, cfg_span_second;
    logic [lfbs_pkg::RAMP_BITS-1:0]    cfg_ramp_first, cfg_ramp_second;
    logic [lfbs_pkg::REPEAT_BITS-1:0]  cfg_repeat_total;
    logic [AGE_BITS-1:0]               seq_age;
    logic                              in_second;
    logic [lfbs_pkg::REPEATS_BITS-1:0] repeats_left;
    logic [lfbs_pkg::LEVEL_BITS-1:0]   pwm_pos;

    lfbs_pkg::t_out_item led_results_due [$];
    int        mismatches = 0;
    int        gap_pct;
    int        stall_pct;
    bit        long_hold_req;
    bit        long_hold_done;
    int        quiet_cycles = 0;

    // Advances the shadow sequence by one accepted transaction. Returns 1 when
    // the transaction yields a result, which is then placed in res.
    function automatic bit advance_sequence(input lfbs_pkg::t_in_item it,
                                            output lfbs_pkg::t_out_item res);
        longint from_lvl, to_lvl, span_ticks, ramp_ticks, target, age;
        logic [AGE_BITS-1:0] next_age;
        res = '0;
        if (it.cmd == lfbs_pkg::CMD_RESTART) begin
            in_second    = 1'b0;
            seq_age      = '0;
            repeats_left = (cfg_repeat_total != 0) ? {1'b0, cfg_repeat_total}
                                                   : lfbs_pkg::ENDLESS_MARK;
            return 1'b0;
        end
        age      = longint'(seq_age);
        next_age = (&seq_age) ? seq_age : seq_age + 1'b1;
        if (it.button_pressed) begin
            // Forced on; the phase is frozen but the age still counts.
            res.led_on       = 1'b1;
            res.level_now    = lfbs_pkg::LEVEL_FULL;
            res.in_phase_two = (repeats_left != 0) ? in_second : 1'b0;
            res.finished     = (repeats_left == 0);
        end else if (repeats_left == 0) begin
            res = DONE_RESULT;
        end else begin
            if (!in_second) begin
                from_lvl   = longint'(cfg_level_second);
                to_lvl     = longint'(cfg_level_first);
                span_ticks = longint'(cfg_span_first) * 10;
                ramp_ticks = (span_ticks * longint'(cfg_ramp_first)) / 100;
            end else begin
                from_lvl   = longint'(cfg_level_first);
                to_lvl     = longint'(cfg_level_second);
                span_ticks = longint'(cfg_span_second) * 10;
                ramp_ticks = (span_ticks * longint'(cfg_ramp_second)) / 100;
            end
            // Signed division here truncates toward zero on falling ramps.
            if (span_ticks == 0 || age >= ramp_ticks)
                target = to_lvl;
            else
                target = from_lvl + ((to_lvl - from_lvl) * age) / ramp_ticks;
            res.level_now    = target[lfbs_pkg::LEVEL_BITS-1:0];
            res.led_on       = (longint'(pwm_pos) < target);
            res.in_phase_two = in_second;
            if (span_ticks != 0 && age >= span_ticks) begin
                if (!in_second) begin
                    in_second = 1'b1;
                end else begin
                    if (!repeats_left[lfbs_pkg::REPEATS_BITS-1] && repeats_left != 0)
                        repeats_left = repeats_left - 1'b1;
                    if (repeats_left != 0)
                        in_second = 1'b0;
                    else
                        res = DONE_RESULT;
                end
                next_age = AGE_BITS'(1);
            end
        end
        seq_age = next_age;
        pwm_pos = (pwm_pos >= lfbs_pkg::PWM_LAST) ? '0 : pwm_pos + 1'b1;
        return 1'b1;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    function automatic logic [lfbs_pkg::SPAN_BITS-1:0] pick_span();
        int unsigned roll = $urandom_range(99);
        if (roll < 10)
            return '0;
        if (roll < 22)
            return lfbs_pkg::SPAN_BITS'($urandom_range(16'hFFFF));
        return lfbs_pkg::SPAN_BITS'($urandom_range(1, 3));
    endfunction

    // Called at a falling edge; returns at a falling edge with valid still high,
    // so back-to-back transactions never drop valid in between.
    task automatic send_item(input lfbs_pkg::t_in_item it, input bit typed,
                             input lfbs_pkg::t_out_item want);
        lfbs_pkg::t_out_item predicted;
        while ($urandom_range(99) < gap_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.payload <= it;
        do @(posedge i_clk); while (!in_if.ready);
        if (advance_sequence(it, predicted))
            led_results_due.push_back(typed ? want : predicted);
        @(negedge i_clk);
    endtask

    // Stops offering, waits for every outstanding result, then lets a restart
    // or any tick still in flight settle before registers may change.
    task automatic drain_results();
        in_if.valid <= 1'b0;
        while (led_results_due.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [lfbs_pkg::CFG_IDX_BITS-1:0] idx,
                             input logic [lfbs_pkg::CFG_DATA_BITS-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
        case (idx)
            lfbs_pkg::CFG_LEVEL_FIRST:  cfg_level_first  = val[lfbs_pkg::LEVEL_BITS-1:0];
            lfbs_pkg::CFG_SPAN_FIRST:   cfg_span_first   = val[lfbs_pkg::SPAN_BITS-1:0];
            lfbs_pkg::CFG_RAMP_FIRST:   cfg_ramp_first   = val[lfbs_pkg::RAMP_BITS-1:0];
            lfbs_pkg::CFG_LEVEL_SECOND: cfg_level_second = val[lfbs_pkg::LEVEL_BITS-1:0];
            lfbs_pkg::CFG_SPAN_SECOND:  cfg_span_second  = val[lfbs_pkg::SPAN_BITS-1:0];
            lfbs_pkg::CFG_RAMP_SECOND:  cfg_ramp_second  = val[lfbs_pkg::RAMP_BITS-1:0];
            lfbs_pkg::CFG_REPEAT_TOTAL: cfg_repeat_total = val[lfbs_pkg::REPEAT_BITS-1:0];
            default: ;
        endcase
    endtask

    // Result side: random stalls, plus one long hold-off on request so that the
    // block fills up and pushes back on its input.
    initial begin : result_sink
        int hold_left;
        hold_left      = 0;
        long_hold_done = 1'b0;
        out_if.ready   = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold_req && !long_hold_done) begin
                hold_left      = LONG_HOLD_CYCLES;
                long_hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                out_if.ready <= 1'b0;
                hold_left--;
            end else begin
                out_if.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        lfbs_pkg::t_out_item want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (led_results_due.size() == 0) begin
                $display("%0t: result with none expected, actual led %0d level %0d p2 %0d fin %0d",
                         $time, out_if.payload.led_on, out_if.payload.level_now,
                         out_if.payload.in_phase_two, out_if.payload.finished);
                mismatches++;
            end else begin
                want = led_results_due.pop_front();
                check_field("led_on", want.led_on, out_if.payload.led_on);
                check_field("level_now", want.level_now, out_if.payload.level_now);
                check_field("in_phase_two", want.in_phase_two, out_if.payload.in_phase_two);
                check_field("finished", want.finished, out_if.payload.finished);
            end
        end
    end

    // Ends a hung run: any transaction or register write restarts the count.
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || i_cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        t_row                               row;
        lfbs_pkg::t_in_item                 it;
        int unsigned                        roll;
        logic [lfbs_pkg::CFG_DATA_BITS-1:0] lvl1, spn1, rmp1, lvl2, spn2, rmp2, rpt;

        i_rst_n       = 1'b0;
        in_if.valid   = 1'b0;
        in_if.payload = '0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = lfbs_pkg::CFG_LEVEL_FIRST;
        i_cfg_data    = '0;
        gap_pct       = 0;
        stall_pct     = 0;
        long_hold_req = 1'b0;

        // Reset state: everything cleared, sequence finished and dark.
        cfg_level_first  = '0;
        cfg_span_first   = '0;
        cfg_ramp_first   = '0;
        cfg_level_second = '0;
        cfg_span_second  = '0;
        cfg_ramp_second  = '0;
        cfg_repeat_total = '0;
        seq_age          = '0;
        in_second        = 1'b0;
        repeats_left     = '0;
        pwm_pos          = '0;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int r = 0; r < NUM_ROWS; r++) begin
            row = DIRECTED_ROWS[r];
            if (row.kind == ROW_REG) begin
                drain_results();
                write_reg(row.reg_idx, row.reg_val);
            end else begin
                repeat (row.count) send_item(row.item, row.typed, row.want);
            end
        end

        // Random part: each set gets fresh registers and one idling style.
        // Short spans dominate so phase flips and repeat ends come often.
        for (int s = 0; s < NUM_SETS; s++) begin
            drain_results();
            case (s % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 62; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 62; end
                default: begin gap_pct = 11; stall_pct = 11; end
            endcase
            case (s)
                0: begin
                    lvl1 = 16'd127; spn1 = 16'hFFFF; rmp1 = 16'd127;
                    lvl2 = 16'd127; spn2 = 16'hFFFF; rmp2 = 16'd127; rpt = 16'd255;
                end
                1: begin
                    lvl1 = 16'd0; spn1 = 16'd0; rmp1 = 16'd0;
                    lvl2 = 16'd0; spn2 = 16'd0; rmp2 = 16'd0; rpt = 16'd0;
                end
                2: begin
                    lvl1 = 16'd100; spn1 = 16'd1; rmp1 = 16'd100;
                    lvl2 = 16'd0;   spn2 = 16'd1; rmp2 = 16'd50;  rpt = 16'd2;
                end
                default: begin
                    lvl1 = lfbs_pkg::CFG_DATA_BITS'($urandom_range(127));
                    spn1 = pick_span();
                    rmp1 = lfbs_pkg::CFG_DATA_BITS'($urandom_range(127));
                    lvl2 = lfbs_pkg::CFG_DATA_BITS'($urandom_range(127));
                    spn2 = pick_span();
                    rmp2 = lfbs_pkg::CFG_DATA_BITS'($urandom_range(127));
                    roll = $urandom_range(99);
                    rpt  = (roll < 20) ? 16'd0 :
                           (roll < 40) ? lfbs_pkg::CFG_DATA_BITS'($urandom_range(255))
                                       : lfbs_pkg::CFG_DATA_BITS'($urandom_range(1, 3));
                end
            endcase
            write_reg(lfbs_pkg::CFG_LEVEL_FIRST, lvl1);
            write_reg(lfbs_pkg::CFG_SPAN_FIRST, spn1);
            write_reg(lfbs_pkg::CFG_RAMP_FIRST, rmp1);
            write_reg(lfbs_pkg::CFG_LEVEL_SECOND, lvl2);
            write_reg(lfbs_pkg::CFG_SPAN_SECOND, spn2);
            write_reg(lfbs_pkg::CFG_RAMP_SECOND, rmp2);
            write_reg(lfbs_pkg::CFG_REPEAT_TOTAL, rpt);

            for (int n = 0; n < ITEMS_PER_SET; n++) begin
                if (s == 5 && n == 10)
                    long_hold_req = 1'b1;
                if (s == 7 && n == 24)
                    drain_results();
                roll = $urandom_range(99);
                it.cmd            = (n == 0 || roll < 4) ? lfbs_pkg::CMD_RESTART
                                                         : lfbs_pkg::CMD_TICK;
                it.button_pressed = (roll >= 86);
                send_item(it, 1'b0, UNTYPED);
            end
        end

        drain_results();
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+src
src/lfbs_pkg.sv
src/lfbs_stream_if.sv
src/lfbs_divider.sv
src/led_fade_blink_sequencer.sv
dv/tb_led_fade_blink_sequencer.sv
